[src/rwc_pkg.sv]
// Package for the RIFF/WAVE chunk locator: tag words, status codes, result type.
// No dependencies; used by the channel interfaces and the top level.
package rwc_pkg;

    localparam int unsigned WordW = 32;

    localparam logic [WordW-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WordW-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WordW-1:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [WordW-1:0] TAG_DATA = 32'h6174_6164;
    localparam logic [WordW-1:0] FMT_MIN_LEN = 32'd14;
    localparam logic [WordW-1:0] WORD_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ST_FMT_SHORT = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    typedef struct packed {
        logic [2:0]       status;
        logic [WordW-1:0] format_offset;
        logic [WordW-1:0] samples_offset;
        logic [WordW-1:0] samples_size;
    } t_result;

endpackage

[src/rwc_if.sv]
// Channel interfaces of the chunk locator: file byte stream in, location word out.
// Depends on rwc_pkg.
interface rwc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface rwc_loc_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [rwc_pkg::WordW-1:0]  format_offset;
    logic [rwc_pkg::WordW-1:0]  samples_offset;
    logic [rwc_pkg::WordW-1:0]  samples_size;

    modport source (output valid, output status, output format_offset,
                    output samples_offset, output samples_size, input ready);
    modport sink   (input valid, input status, input format_offset,
                    input samples_offset, input samples_size, output ready);
endinterface

[src/riff_wave_chunk_locator_unit.sv]
// RIFF/WAVE chunk locator top level: parses a WAV byte stream and reports
// where the fmt and data chunk bodies lie. Depends on rwc_pkg and rwc_if.
// Path: a byte accepted into the input register is parsed there; a result it
//   causes goes into the result register and is held on o_loc until taken.
// Throughput: one byte per cycle; the input stalls only while a result word waits.
// Reset: i_rst_n (synchronous, active low) empties both registers; frame_end restarts.
module riff_wave_chunk_locator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rwc_byte_if.sink      i_byte,
    rwc_loc_if.source     o_loc
);

    // Parser phases
    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_RLEN = 3'd1;
    localparam logic [2:0] PH_WAVE = 3'd2;
    localparam logic [2:0] PH_CTAG = 3'd3;
    localparam logic [2:0] PH_CLEN = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_IDLE = 3'd6;

    // Input register: one byte waiting to be parsed
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_fe;

    // Parser state
    logic [2:0]                r_phase, n_phase;
    logic [1:0]                r_biw, n_biw;
    logic [rwc_pkg::WordW-1:0] r_file_offset, n_file_offset;
    logic [rwc_pkg::WordW-1:0] r_word_shift, n_word_shift;
    logic [rwc_pkg::WordW-1:0] r_riff_end, n_riff_end;
    logic [rwc_pkg::WordW-1:0] r_chunk_tag, n_chunk_tag;
    logic [rwc_pkg::WordW-1:0] r_skip_left, n_skip_left;
    logic                      r_format_seen, n_format_seen;
    logic [rwc_pkg::WordW-1:0] r_format_pos, n_format_pos;
    logic                      r_samples_seen, n_samples_seen;
    logic [rwc_pkg::WordW-1:0] r_samples_pos, n_samples_pos;
    logic [rwc_pkg::WordW-1:0] r_samples_len, n_samples_len;
    logic                      r_decided, n_decided;

    // Result register
    logic             r_out_valid;
    rwc_pkg::t_result r_out;

    logic                      st_valid;
    logic [2:0]                st_code;
    logic                      enter_req;
    logic                      hdr_skip;
    logic                      word_done;
    logic [rwc_pkg::WordW-1:0] nxt;
    logic [rwc_pkg::WordW-1:0] ws_new;
    logic [rwc_pkg::WordW-1:0] pad_len;
    logic [rwc_pkg::WordW-1:0] riff_end_sum;
    logic                      s1_adv;
    logic                      s1_fire;
    rwc_pkg::t_result          res;

    // -------------------------------------------------------------------
    // Parse one byte. All decisions come from the current state and the
    // incoming byte already shifted into the little-endian word.
    // -------------------------------------------------------------------
    always_comb begin
        n_phase        = r_phase;
        n_biw          = r_biw;
        n_file_offset  = r_file_offset;
        n_word_shift   = r_word_shift;
        n_riff_end     = r_riff_end;
        n_chunk_tag    = r_chunk_tag;
        n_skip_left    = r_skip_left;
        n_format_seen  = r_format_seen;
        n_format_pos   = r_format_pos;
        n_samples_seen = r_samples_seen;
        n_samples_pos  = r_samples_pos;
        n_samples_len  = r_samples_len;
        n_decided      = r_decided;
        st_valid       = 1'b0;
        st_code        = rwc_pkg::ST_OK;
        enter_req      = 1'b0;
        hdr_skip       = 1'b0;

        // Saturating increment of the file position
        nxt    = (&r_file_offset) ? r_file_offset : r_file_offset + 32'd1;
        ws_new = {r_s1_byte, r_word_shift[rwc_pkg::WordW-1:8]};
        word_done = (r_biw == 2'd3);
        // Body length rounded up to even, saturating at all ones
        pad_len = (&ws_new) ? rwc_pkg::WORD_MAX : ((ws_new + 32'd1) & 32'hFFFF_FFFE);
        riff_end_sum = (ws_new > 32'hFFFF_FFF7) ? rwc_pkg::WORD_MAX : ws_new + 32'd8;

        if (!r_decided) begin
            n_word_shift = ws_new;
            n_biw        = r_biw + 2'd1;

            case (r_phase)
                PH_RIFF: begin
                    if (word_done) begin
                        if (ws_new != rwc_pkg::TAG_RIFF) begin
                            st_valid = 1'b1;
                            st_code  = rwc_pkg::ST_NOT_RIFF;
                        end else begin
                            n_phase = PH_RLEN;
                        end
                    end
                end
                PH_RLEN: begin
                    if (word_done) begin
                        n_riff_end = riff_end_sum;
                        n_phase    = PH_WAVE;
                    end
                end
                PH_WAVE: begin
                    if (word_done) begin
                        if (ws_new != rwc_pkg::TAG_WAVE) begin
                            st_valid = 1'b1;
                            st_code  = rwc_pkg::ST_NOT_WAVE;
                        end else begin
                            enter_req = 1'b1;
                        end
                    end
                end
                PH_CTAG: begin
                    if (word_done) begin
                        n_chunk_tag = ws_new;
                        n_phase     = PH_CLEN;
                    end
                end
                PH_CLEN: begin
                    if (word_done) begin
                        // Only the first fmt chunk is checked; a data chunk is
                        // replaced only while the one held is empty.
                        if (r_chunk_tag == rwc_pkg::TAG_FMT && !r_format_seen) begin
                            if (ws_new < rwc_pkg::FMT_MIN_LEN) begin
                                st_valid = 1'b1;
                                st_code  = rwc_pkg::ST_FMT_SHORT;
                            end else begin
                                n_format_seen = 1'b1;
                                n_format_pos  = nxt;
                                if (r_samples_seen && r_samples_len != '0) begin
                                    st_valid = 1'b1;
                                    st_code  = rwc_pkg::ST_OK;
                                end else begin
                                    hdr_skip = 1'b1;
                                end
                            end
                        end else if (r_chunk_tag == rwc_pkg::TAG_DATA &&
                                     (!r_samples_seen || r_samples_len == '0)) begin
                            n_samples_seen = 1'b1;
                            n_samples_pos  = nxt;
                            n_samples_len  = ws_new;
                            if (r_format_seen) begin
                                st_valid = 1'b1;
                                st_code  = rwc_pkg::ST_OK;
                            end else begin
                                hdr_skip = 1'b1;
                            end
                        end else begin
                            hdr_skip = 1'b1;
                        end

                        if (hdr_skip) begin
                            if (ws_new == '0) begin
                                enter_req = 1'b1;
                            end else begin
                                n_skip_left = pad_len;
                                n_phase     = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_skip_left != '0) begin
                        n_skip_left = r_skip_left - 32'd1;
                    end
                    if (r_skip_left <= 32'd1) begin
                        enter_req = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Next header would start at or past the end of the RIFF list
            if (enter_req) begin
                if (nxt >= r_riff_end) begin
                    st_valid = 1'b1;
                    st_code  = rwc_pkg::ST_EXHAUSTED;
                end else begin
                    n_phase = PH_CTAG;
                    n_biw   = 2'd0;
                end
            end

            n_file_offset = nxt;

            if (!st_valid && r_s1_fe) begin
                st_valid = 1'b1;
                st_code  = rwc_pkg::ST_TRUNCATED;
            end

            if (st_valid) begin
                n_decided = 1'b1;
                n_phase   = PH_IDLE;
            end
        end

        res.status         = st_code;
        res.format_offset  = n_format_seen  ? n_format_pos  : '0;
        res.samples_offset = n_samples_seen ? n_samples_pos : '0;
        res.samples_size   = n_samples_seen ? n_samples_len : '0;
    end

    // Advance the parse stage unless it makes a result that has nowhere to go
    assign s1_adv  = !st_valid || !r_out_valid || o_loc.ready;
    assign s1_fire = r_s1_valid && s1_adv;

    assign i_byte.ready = !r_s1_valid || s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_s1_byte <= i_byte.data_byte;
            r_s1_fe   <= i_byte.frame_end;
        end
    end

    // Parser state: frame end returns everything to the start of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_fire && r_s1_fe)) begin
            r_phase        <= PH_RIFF;
            r_biw          <= '0;
            r_file_offset  <= '0;
            r_word_shift   <= '0;
            r_riff_end     <= '0;
            r_chunk_tag    <= '0;
            r_skip_left    <= '0;
            r_format_seen  <= 1'b0;
            r_format_pos   <= '0;
            r_samples_seen <= 1'b0;
            r_samples_pos  <= '0;
            r_samples_len  <= '0;
            r_decided      <= 1'b0;
        end else if (s1_fire) begin
            r_phase        <= n_phase;
            r_biw          <= n_biw;
            r_file_offset  <= n_file_offset;
            r_word_shift   <= n_word_shift;
            r_riff_end     <= n_riff_end;
            r_chunk_tag    <= n_chunk_tag;
            r_skip_left    <= n_skip_left;
            r_format_seen  <= n_format_seen;
            r_format_pos   <= n_format_pos;
            r_samples_seen <= n_samples_seen;
            r_samples_pos  <= n_samples_pos;
            r_samples_len  <= n_samples_len;
            r_decided      <= n_decided;
        end
    end

    // Result register: hold the word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && st_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_loc.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && st_valid) begin
            r_out <= res;
        end
    end

    assign o_loc.valid          = r_out_valid;
    assign o_loc.status         = r_out.status;
    assign o_loc.format_offset  = r_out.format_offset;
    assign o_loc.samples_offset = r_out.samples_offset;
    assign o_loc.samples_size   = r_out.samples_size;

    // -------------------------------------------------------------------
    // Checks
    // -------------------------------------------------------------------
    a_decided_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decided |-> (r_phase == PH_IDLE))
        else $error("decided parser not idle");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip_left != '0))
        else $error("skip phase with empty skip count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && st_valid) |-> (!r_out_valid || o_loc.ready))
        else $error("result overwrites a pending word");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status <= rwc_pkg::ST_TRUNCATED))
        else $error("status code out of range");

endmodule

[dv/tb_riff_wave_chunk_locator_unit.sv]
// Testbench for riff_wave_chunk_locator_unit: streams WAV files byte by byte and
// checks every location word against a predictor of the chunk walk.
// Depends on rwc_pkg, rwc_byte_if / rwc_loc_if and the top level RTL.
`timescale 1ns / 1ps

module tb_riff_wave_chunk_locator_unit;

    // Parser phases of the predictor, one per field of the file header walk.
    typedef enum logic [2:0] {
        PRS_RIFF, PRS_RLEN, PRS_WAVE, PRS_CTAG, PRS_CLEN, PRS_SKIP, PRS_IDLE
    } t_parse_phase;

    // One row of the directed stimulus. Where typed is set, the row must end
    // the file walk with the given status and all offsets still zero.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic       typed;
        logic [2:0] status;
    } t_dir_row;

    localparam int unsigned RAND_BYTES  = 1000;
    localparam int unsigned RAND_FILES  = 36;
    localparam int unsigned LONG_HOLD   = 1500;
    localparam int unsigned PRESSURE_AT = 10;
    localparam int unsigned DRAIN_LIMIT = 2000;

    // Directed files: truncation on the first byte, a broken RIFF tag ending
    // on 0xFF, a broken WAVE tag behind a saturating RIFF length, and a chunk
    // list that is already over right after the WAVE tag.
    localparam t_dir_row DIR_ROWS [29] = '{
        '{8'h52, 1'b1, 1'b1, rwc_pkg::ST_TRUNCATED},
        '{8'h52, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h49, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h46, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'hFF, 1'b1, 1'b1, rwc_pkg::ST_NOT_RIFF},
        '{8'h52, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h49, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h46, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h46, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h57, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h41, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h56, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h00, 1'b1, 1'b1, rwc_pkg::ST_NOT_WAVE},
        '{8'h52, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h49, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h46, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h46, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h04, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h57, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h41, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h56, 1'b0, 1'b0, rwc_pkg::ST_OK},
        '{8'h45, 1'b1, 1'b1, rwc_pkg::ST_EXHAUSTED}
    };

    logic i_clk;
    logic i_rst_n;

    rwc_byte_if byte_ch ();
    rwc_loc_if  loc_ch ();

    riff_wave_chunk_locator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_loc   (loc_ch)
    );

    // Predictor state: a private copy of the chunk walk.
    t_parse_phase prd_phase;
    logic [1:0]   prd_byte_idx;
    logic [31:0]  prd_offset;
    logic [31:0]  prd_word;
    logic [31:0]  prd_riff_end;
    logic [31:0]  prd_tag;
    logic [31:0]  prd_skip;
    logic         prd_fmt_seen;
    logic [31:0]  prd_fmt_pos;
    logic         prd_dat_seen;
    logic [31:0]  prd_dat_pos;
    logic [31:0]  prd_dat_len;
    logic         prd_decided;
    logic         prd_hit;
    logic [2:0]   prd_status;

    rwc_pkg::t_result loc_expected [$];
    logic [7:0]       wav_bytes [$];
    int unsigned      mismatch_count;
    int unsigned      parsed_bytes;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Guard against a hung handshake.
    initial begin
        #10ms;
        $display("riff_wave_chunk_locator_unit verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH @%0t %s: got 0x%08h expected 0x%08h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
        logic [33:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, rwc_pkg::WORD_MAX}) ? rwc_pkg::WORD_MAX : s[31:0];
    endfunction

    function automatic void reset_locator();
        prd_phase    = PRS_RIFF;
        prd_byte_idx = '0;
        prd_offset   = '0;
        prd_word     = '0;
        prd_riff_end = '0;
        prd_tag      = '0;
        prd_skip     = '0;
        prd_fmt_seen = 1'b0;
        prd_fmt_pos  = '0;
        prd_dat_seen = 1'b0;
        prd_dat_pos  = '0;
        prd_dat_len  = '0;
        prd_decided  = 1'b0;
    endfunction

    function automatic void decide(input logic [2:0] st);
        prd_hit    = 1'b1;
        prd_status = st;
    endfunction

    // Step to the chunk header at nxt, or close the list when it lies at or past the end.
    function automatic void next_chunk(input logic [31:0] nxt);
        if (nxt >= prd_riff_end) begin
            decide(rwc_pkg::ST_EXHAUSTED);
        end else begin
            prd_phase    = PRS_CTAG;
            prd_byte_idx = '0;
        end
    endfunction

    function automatic void header_done(input logic [31:0] len, input logic [31:0] body);
        logic [32:0] pad;
        if (prd_tag == rwc_pkg::TAG_FMT && !prd_fmt_seen) begin
            if (len < rwc_pkg::FMT_MIN_LEN) begin
                decide(rwc_pkg::ST_FMT_SHORT);
                return;
            end
            prd_fmt_seen = 1'b1;
            prd_fmt_pos  = body;
            if (prd_dat_seen && prd_dat_len != 0) begin
                decide(rwc_pkg::ST_OK);
                return;
            end
        end else if (prd_tag == rwc_pkg::TAG_DATA && (!prd_dat_seen || prd_dat_len == 0)) begin
            prd_dat_seen = 1'b1;
            prd_dat_pos  = body;
            prd_dat_len  = len;
            if (prd_fmt_seen) begin
                decide(rwc_pkg::ST_OK);
                return;
            end
        end
        // Skip the body, padded to even length and saturated at the word maximum.
        pad = ({1'b0, len} + 33'd1) & ~33'd1;
        if (pad > {1'b0, rwc_pkg::WORD_MAX})
            pad = {1'b0, rwc_pkg::WORD_MAX};
        if (pad == 0) begin
            next_chunk(body);
            return;
        end
        prd_skip  = pad[31:0];
        prd_phase = PRS_SKIP;
    endfunction

    // Advance the predictor by one byte; return 1 with res filled when it decides.
    function automatic bit locate_chunks_step(input logic [7:0] b, input logic fe,
                                              output rwc_pkg::t_result res);
        logic        word_done;
        logic [31:0] nxt;
        bit          found;
        found      = 1'b0;
        res        = '0;
        prd_hit    = 1'b0;
        prd_status = rwc_pkg::ST_OK;
        if (!prd_decided) begin
            word_done    = (prd_byte_idx == 2'd3);
            nxt          = sat_add(prd_offset, 33'd1);
            prd_word     = {b, prd_word[31:8]};
            prd_byte_idx = prd_byte_idx + 2'd1;
            case (prd_phase)
                PRS_RIFF: if (word_done) begin
                    if (prd_word != rwc_pkg::TAG_RIFF)
                        decide(rwc_pkg::ST_NOT_RIFF);
                    else
                        prd_phase = PRS_RLEN;
                end
                PRS_RLEN: if (word_done) begin
                    prd_riff_end = sat_add(32'd8, {1'b0, prd_word});
                    prd_phase    = PRS_WAVE;
                end
                PRS_WAVE: if (word_done) begin
                    if (prd_word != rwc_pkg::TAG_WAVE)
                        decide(rwc_pkg::ST_NOT_WAVE);
                    else
                        next_chunk(nxt);
                end
                PRS_CTAG: if (word_done) begin
                    prd_tag   = prd_word;
                    prd_phase = PRS_CLEN;
                end
                PRS_CLEN: if (word_done) begin
                    header_done(prd_word, nxt);
                end
                PRS_SKIP: begin
                    if (prd_skip != 0)
                        prd_skip = prd_skip - 32'd1;
                    if (prd_skip == 0)
                        next_chunk(nxt);
                end
                default: begin
                end
            endcase
            prd_offset = nxt;
            if (!prd_hit && fe)
                decide(rwc_pkg::ST_TRUNCATED);
            if (prd_hit) begin
                res.status         = prd_status;
                res.format_offset  = prd_fmt_seen ? prd_fmt_pos : '0;
                res.samples_offset = prd_dat_seen ? prd_dat_pos : '0;
                res.samples_size   = prd_dat_seen ? prd_dat_len : '0;
                prd_decided        = 1'b1;
                prd_phase          = PRS_IDLE;
                found              = 1'b1;
            end
        end
        if (fe)
            reset_locator();
        return found;
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            wav_bytes.push_back(w[8*i +: 8]);
    endfunction

    // Build one file into wav_bytes: mostly well-formed chunk lists with random
    // contents, plus noise, corrupted tags, odd RIFF lengths and early cuts.
    function automatic void build_wav_file();
        int unsigned n_chunks;
        int unsigned body_len;
        int unsigned cut;
        logic [31:0] tag;
        logic [31:0] len_field;
        logic [31:0] riff_len;
        wav_bytes.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 24))
                wav_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        put_word(rwc_pkg::TAG_RIFF);
        put_word(32'd0);
        put_word(rwc_pkg::TAG_WAVE);
        n_chunks = $urandom_range(1, 4);
        for (int c = 0; c < n_chunks; c++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    tag      = rwc_pkg::TAG_FMT;
                    body_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 13)
                                                           : $urandom_range(14, 18);
                end
                3, 4, 5: begin
                    tag      = rwc_pkg::TAG_DATA;
                    body_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
                default: begin
                    tag      = $urandom;
                    body_len = $urandom_range(0, 7);
                end
            endcase
            len_field = body_len;
            // Now and then claim a huge body to push the skip count to saturation.
            if ($urandom_range(0, 24) == 0)
                len_field = rwc_pkg::WORD_MAX - $urandom_range(0, 3);
            put_word(tag);
            put_word(len_field);
            repeat ((body_len + 1) & ~1)
                wav_bytes.push_back(8'($urandom_range(0, 255)));
        end
        riff_len = wav_bytes.size() - 8;
        case ($urandom_range(0, 9))
            0: riff_len = $urandom;
            1: riff_len = riff_len - $urandom_range(1, 12);
            2: riff_len = rwc_pkg::WORD_MAX;
            default: begin
            end
        endcase
        for (int i = 0; i < 4; i++)
            wav_bytes[4 + i] = riff_len[8*i +: 8];
        if ($urandom_range(0, 9) == 0)
            wav_bytes[$urandom_range(0, 11)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, wav_bytes.size());
            while (wav_bytes.size() > cut)
                void'(wav_bytes.pop_back());
        end else if ($urandom_range(0, 7) == 0) begin
            // Trailing bytes after the decision are ignored by the block.
            repeat ($urandom_range(1, 4))
                wav_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offer one byte word after gap idle cycles, wait for it to be taken, then
    // queue what it should cause. Keep valid high across back-to-back words.
    task automatic feed_byte(input logic [7:0] b, input logic fe, input int unsigned gap,
                             input logic typed, input logic [2:0] typed_status);
        rwc_pkg::t_result res;
        bit               found;
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.frame_end <= fe;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        if (!prd_decided)
            parsed_bytes++;
        found = locate_chunks_step(b, fe, res);
        if (typed)
            loc_expected.push_back('{typed_status, 32'd0, 32'd0, 32'd0});
        else if (found)
            loc_expected.push_back(res);
    endtask

    // Sender: reset, walk the directed rows, then random files until enough
    // bytes have been parsed and enough files seen, then drain and judge.
    initial begin : byte_sender
        int unsigned files_sent;
        int unsigned guard;
        bit          burst;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.frame_end <= 1'b0;
        i_rst_n           <= 1'b0;
        mismatch_count = 0;
        parsed_bytes   = 0;
        files_sent     = 0;
        reset_locator();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < $size(DIR_ROWS); r++)
            feed_byte(DIR_ROWS[r].data_byte, DIR_ROWS[r].frame_end, $urandom_range(0, 9),
                      DIR_ROWS[r].typed, DIR_ROWS[r].status);

        while (parsed_bytes < RAND_BYTES || files_sent < RAND_FILES) begin
            build_wav_file();
            // Send about one file in four without any idle cycles.
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < wav_bytes.size(); i++)
                feed_byte(wav_bytes[i], i == wav_bytes.size() - 1,
                          burst ? 0 : $urandom_range(0, 9), 1'b0, rwc_pkg::ST_OK);
            files_sent++;
        end
        byte_ch.valid <= 1'b0;

        // Drain: let outstanding results arrive, then allow the pipeline latency.
        guard = 0;
        while (loc_expected.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (loc_expected.size() != 0)
            report_mismatch("results never delivered", 32'(loc_expected.size()), 32'd0);
        if (mismatch_count == 0)
            $display("riff_wave_chunk_locator_unit verification clean");
        else
            $display("riff_wave_chunk_locator_unit verification failed");
        $finish;
    end

    // Receiver: stall a random number of cycles before each result word, with
    // stall-free stretches, and one long hold-off so the block backs up.
    initial begin : loc_receiver
        int unsigned      hold;
        int unsigned      seen;
        bit               calm;
        rwc_pkg::t_result want;
        loc_ch.ready <= 1'b0;
        seen = 0;
        calm = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (seen % 8 == 0)
                calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, 9);
            if (seen == PRESSURE_AT)
                hold = LONG_HOLD;
            if (hold != 0) begin
                loc_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            loc_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!loc_ch.valid)
                @(posedge i_clk);
            // Compare the taken word field by field with the oldest expectation.
            if (loc_expected.size() == 0) begin
                report_mismatch("result with none pending", 32'(loc_ch.status), 32'd0);
            end else begin
                want = loc_expected.pop_front();
                if (loc_ch.status != want.status)
                    report_mismatch("status", 32'(loc_ch.status), 32'(want.status));
                if (loc_ch.format_offset != want.format_offset)
                    report_mismatch("format_offset", loc_ch.format_offset,
                                    want.format_offset);
                if (loc_ch.samples_offset != want.samples_offset)
                    report_mismatch("samples_offset", loc_ch.samples_offset,
                                    want.samples_offset);
                if (loc_ch.samples_size != want.samples_size)
                    report_mismatch("samples_size", loc_ch.samples_size,
                                    want.samples_size);
            end
            seen++;
        end
    end

endmodule
